/* rtl/psh_pkg.sv */
// ----------------------------------------------------------------------------
// psh_pkg
// Shared types, widths and codes of the phase-space histogram.
// ----------------------------------------------------------------------------
`default_nettype none

package psh_pkg;

    // default sizes of the bin store
    localparam int CELLS_DEF             = 16;
    localparam int VELOCITY_BINS_MAX_DEF = 16;
    localparam int MOMENT_BINS_MAX_DEF   = 16;

    // field widths
    localparam int COORD_W     = 32;
    localparam int INV_W       = 32;
    localparam int NBINS_W     = 5;
    localparam int WEIGHT_W    = 32;
    localparam int BIN_VALUE_W = 48;
    localparam int COUNT_W     = 32;
    localparam int CELL_W      = 4;
    localparam int RBIN_W      = 4;
    localparam int ACTION_W    = 2;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 32;
    localparam int S_TDATA_W   = 80;
    localparam int M_TDATA_W   = 112;

    // action codes
    localparam logic [ACTION_W-1:0] ACT_DEPOSIT = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_READ    = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_COUNT   = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_VELOCITY_MIN  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_VELOCITY_INV  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_VELOCITY_BINS = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MOMENT_MIN    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MOMENT_INV    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_MOMENT_BINS   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_BIN_WEIGHT    = 3'd6;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MUL,
        ST_ACCESS,
        ST_WRITE
    } state_t;

    function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] c);
        sat_inc = (c == {COUNT_W{1'b1}}) ? c : c + COUNT_W'(1);
    endfunction

endpackage

`default_nettype wire

/* rtl/psh_bin_ram.sv */
// ----------------------------------------------------------------------------
// psh_bin_ram
// Bin store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module psh_bin_ram
    import psh_pkg::*;
#(
    parameter int DEPTH  = CELLS_DEF * VELOCITY_BINS_MAX_DEF * MOMENT_BINS_MAX_DEF,
    parameter int ADDR_W = 12
) (
    input  wire logic                   aclk,
    input  wire logic                   we,
    input  wire logic [ADDR_W-1:0]      waddr,
    input  wire logic [BIN_VALUE_W-1:0] wdata,
    input  wire logic                   re,
    input  wire logic [ADDR_W-1:0]      raddr,
    output logic      [BIN_VALUE_W-1:0] rdata
);

    logic [BIN_VALUE_W-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

/* rtl/psh_axis_bin.sv */
// ----------------------------------------------------------------------------
// psh_axis_bin
// One histogram axis: offset from the lower edge, multiply by the inverse
// bin width and range check of floor((x - min) * inverse_step).
// ----------------------------------------------------------------------------
`default_nettype none

module psh_axis_bin
    import psh_pkg::*;
#(
    parameter int BINS_MAX = VELOCITY_BINS_MAX_DEF,
    parameter int BIN_W    = 4
) (
    input  wire logic               aclk,
    input  wire logic               load,
    input  wire logic [COORD_W-1:0] x,
    input  wire logic [COORD_W-1:0] lo,
    input  wire logic [INV_W-1:0]   inv,
    input  wire logic               mul_en,
    input  wire logic [NBINS_W-1:0] bin_count,
    output logic                    in_range,
    output logic      [BIN_W-1:0]   bin
);

    logic [COORD_W:0]           diff;
    logic [COORD_W-1:0]         diff_reg;
    logic                       fail_reg;
    logic [COORD_W+INV_W-1:0]   prod_reg;
    logic [COORD_W-1:0]         prod_hi;
    logic [COORD_W-1:0]         lim;

    // exact 33-bit signed difference
    assign diff = {x[COORD_W-1], x} - {lo[COORD_W-1], lo};

    always_ff @(posedge aclk) begin
        if (load) begin
            // negative offset lands below the axis unless the step is zero
            diff_reg <= diff[COORD_W] ? '0 : diff[COORD_W-1:0];
            fail_reg <= diff[COORD_W] && (inv != '0);
        end
    end

    always_ff @(posedge aclk) begin
        if (mul_en) begin
            prod_reg <= (COORD_W+INV_W)'(diff_reg) * (COORD_W+INV_W)'(inv);
        end
    end

    assign prod_hi  = prod_reg[COORD_W+INV_W-1:INV_W];
    assign lim      = (COORD_W'(bin_count) > COORD_W'(BINS_MAX)) ? COORD_W'(BINS_MAX)
                                                               : COORD_W'(bin_count);
    assign in_range = !fail_reg && (prod_hi < lim);
    assign bin      = prod_hi[BIN_W-1:0];

endmodule

`default_nettype wire

/* rtl/phase_space_histogram.sv */
// An accepted request passes through ST_MUL, ST_ACCESS and ST_WRITE; its result is
// registered onto m_tvalid as ST_WRITE ends. No new request is taken until the
// binning multiply and the read-modify-write of the bin memory (registered read) are
// done; a pending result waits in the output register as the next request is taken.
// Reset: counters and config return to defaults, then a clearing pass writes
// zero to all CELLS*VELOCITY_BINS_MAX*MOMENT_BINS_MAX bins.
// ----------------------------------------------------------------------------
// phase_space_histogram
// Per-cell 2D histogram over parallel velocity and magnetic moment with
// saturating 48-bit bins and included / omitted particle counters.
// ----------------------------------------------------------------------------
`default_nettype none

module phase_space_histogram
    import psh_pkg::*;
#(
    parameter int CELLS             = CELLS_DEF,
    parameter int VELOCITY_BINS_MAX = VELOCITY_BINS_MAX_DEF,
    parameter int MOMENT_BINS_MAX   = MOMENT_BINS_MAX_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // cell_index, parallel_velocity, magnetic_moment, read_velocity_bin,
    // read_moment_bin, zero pad
    input  wire logic [S_TDATA_W-1:0]  s_tdata,
    // action
    input  wire logic [ACTION_W-1:0]   s_tuser,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // bin_value, included_count, omitted_count
    output logic      [M_TDATA_W-1:0]  m_tdata,
    // deposited
    output logic      [0:0]            m_tuser,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

    localparam int DEPTH  = CELLS * VELOCITY_BINS_MAX * MOMENT_BINS_MAX;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int VBIN_W = (VELOCITY_BINS_MAX > 1) ? $clog2(VELOCITY_BINS_MAX) : 1;
    localparam int MBIN_W = (MOMENT_BINS_MAX > 1) ? $clog2(MOMENT_BINS_MAX) : 1;

    // configuration
    logic [COORD_W-1:0]  vel_min_reg, mom_min_reg;
    logic [INV_W-1:0]    vel_inv_reg, mom_inv_reg;
    logic [NBINS_W-1:0]  vel_bins_reg, mom_bins_reg;
    logic [WEIGHT_W-1:0] weight_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vel_min_reg  <= '0;
            vel_inv_reg  <= INV_W'(65536);
            vel_bins_reg <= NBINS_W'(16);
            mom_min_reg  <= '0;
            mom_inv_reg  <= INV_W'(65536);
            mom_bins_reg <= NBINS_W'(16);
            weight_reg   <= WEIGHT_W'(65536);
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_VELOCITY_MIN:  vel_min_reg  <= cfg_wdata[COORD_W-1:0];
                CFG_VELOCITY_INV:  vel_inv_reg  <= cfg_wdata[INV_W-1:0];
                CFG_VELOCITY_BINS: vel_bins_reg <= cfg_wdata[NBINS_W-1:0];
                CFG_MOMENT_MIN:    mom_min_reg  <= cfg_wdata[COORD_W-1:0];
                CFG_MOMENT_INV:    mom_inv_reg  <= cfg_wdata[INV_W-1:0];
                CFG_MOMENT_BINS:   mom_bins_reg <= cfg_wdata[NBINS_W-1:0];
                CFG_BIN_WEIGHT:    weight_reg   <= cfg_wdata[WEIGHT_W-1:0];
                default: ;
            endcase
        end
    end

    // request fields
    logic [CELL_W-1:0]  s_cell;
    logic [COORD_W-1:0] s_vpar, s_mom;
    logic [RBIN_W-1:0]  s_rv, s_rm;

    assign s_cell = s_tdata[3:0];
    assign s_vpar = s_tdata[35:4];
    assign s_mom  = s_tdata[67:36];
    assign s_rv   = s_tdata[71:68];
    assign s_rm   = s_tdata[75:72];

    state_t state_reg, state_next;
    logic   accept, mul_en, access_en, out_free, finish;

    logic [ACTION_W-1:0] act_reg;
    logic [CELL_W-1:0]   cell_reg;
    logic [RBIN_W-1:0]   rv_reg, rm_reg;

    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_tvalid || m_tready;

    always_ff @(posedge aclk) begin
        if (accept) begin
            act_reg  <= s_tuser;
            cell_reg <= s_cell;
            rv_reg   <= s_rv;
            rm_reg   <= s_rm;
        end
    end

    // binning units
    logic              v_ok, m_ok;
    logic [VBIN_W-1:0] v_bin;
    logic [MBIN_W-1:0] m_bin;

    psh_axis_bin #(
        .BINS_MAX (VELOCITY_BINS_MAX),
        .BIN_W    (VBIN_W)
    ) u_vel_axis (
        .aclk      (aclk),
        .load      (accept),
        .x         (s_vpar),
        .lo        (vel_min_reg),
        .inv       (vel_inv_reg),
        .mul_en    (mul_en),
        .bin_count (vel_bins_reg),
        .in_range  (v_ok),
        .bin       (v_bin)
    );

    psh_axis_bin #(
        .BINS_MAX (MOMENT_BINS_MAX),
        .BIN_W    (MBIN_W)
    ) u_mom_axis (
        .aclk      (aclk),
        .load      (accept),
        .x         (s_mom),
        .lo        (mom_min_reg),
        .inv       (mom_inv_reg),
        .mul_en    (mul_en),
        .bin_count (mom_bins_reg),
        .in_range  (m_ok),
        .bin       (m_bin)
    );

    // store address and hit decision
    logic              cell_ok, dep_hit, rd_hit;
    logic [ADDR_W-1:0] dep_addr, rd_addr, acc_addr;
    logic [ADDR_W-1:0] addr_reg;
    logic              dep_hit_reg, rd_hit_reg;

    assign cell_ok  = 32'(cell_reg) < 32'(CELLS);
    assign dep_hit  = (act_reg == ACT_DEPOSIT) && v_ok && m_ok && cell_ok;
    assign rd_hit   = (act_reg == ACT_READ) && cell_ok
                      && (32'(rv_reg) < 32'(VELOCITY_BINS_MAX))
                      && (32'(rm_reg) < 32'(MOMENT_BINS_MAX));
    assign dep_addr = ADDR_W'(cell_reg) * ADDR_W'(VELOCITY_BINS_MAX * MOMENT_BINS_MAX)
                      + ADDR_W'(v_bin) * ADDR_W'(MOMENT_BINS_MAX) + ADDR_W'(m_bin);
    assign rd_addr  = ADDR_W'(cell_reg) * ADDR_W'(VELOCITY_BINS_MAX * MOMENT_BINS_MAX)
                      + ADDR_W'(rv_reg) * ADDR_W'(MOMENT_BINS_MAX) + ADDR_W'(rm_reg);
    assign acc_addr = (act_reg == ACT_DEPOSIT) ? dep_addr : rd_addr;

    always_ff @(posedge aclk) begin
        if (access_en) begin
            addr_reg    <= acc_addr;
            dep_hit_reg <= dep_hit;
            rd_hit_reg  <= rd_hit;
        end
    end

    // bin memory
    logic                   clear_en, mem_we;
    logic [ADDR_W-1:0]      clr_addr_reg, mem_waddr;
    logic [BIN_VALUE_W-1:0] mem_wdata, mem_rdata;
    logic [BIN_VALUE_W:0]   sum;
    logic [BIN_VALUE_W-1:0] sat_sum;

    assign sum     = {1'b0, mem_rdata} + (BIN_VALUE_W+1)'(weight_reg);
    assign sat_sum = sum[BIN_VALUE_W] ? {BIN_VALUE_W{1'b1}} : sum[BIN_VALUE_W-1:0];

    assign mem_we    = clear_en || (finish && (dep_hit_reg || rd_hit_reg));
    assign mem_waddr = clear_en ? clr_addr_reg : addr_reg;
    assign mem_wdata = (!clear_en && dep_hit_reg) ? sat_sum : '0;

    psh_bin_ram #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_bin_ram (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (access_en && (dep_hit || rd_hit)),
        .raddr (acc_addr),
        .rdata (mem_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_addr_reg <= '0;
        end else if (clear_en) begin
            clr_addr_reg <= clr_addr_reg + ADDR_W'(1);
        end
    end

    // controller
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        s_tready   = 1'b0;
        mul_en     = 1'b0;
        access_en  = 1'b0;
        finish     = 1'b0;
        clear_en   = 1'b0;
        unique case (state_reg)
            ST_CLEAR: begin
                clear_en = 1'b1;
                if (clr_addr_reg == ADDR_W'(DEPTH - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                mul_en     = 1'b1;
                state_next = ST_ACCESS;
            end
            ST_ACCESS: begin
                access_en  = 1'b1;
                state_next = ST_WRITE;
            end
            ST_WRITE: begin
                if (out_free) begin
                    finish     = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_CLEAR;
        endcase
    end

    // counters
    logic [COUNT_W-1:0] inc_reg, omit_reg, inc_upd, omit_upd;
    logic               omit_hit;

    assign omit_hit = (act_reg == ACT_DEPOSIT) && !dep_hit_reg;
    assign inc_upd  = dep_hit_reg ? sat_inc(inc_reg) : inc_reg;
    assign omit_upd = omit_hit ? sat_inc(omit_reg) : omit_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            inc_reg  <= '0;
            omit_reg <= '0;
        end else if (finish) begin
            inc_reg  <= (act_reg == ACT_COUNT) ? '0 : inc_upd;
            omit_reg <= (act_reg == ACT_COUNT) ? '0 : omit_upd;
        end
    end

    // output register
    logic                   m_valid_reg;
    logic [BIN_VALUE_W-1:0] bin_out_reg;
    logic [COUNT_W-1:0]     inc_out_reg, omit_out_reg;
    logic                   dep_out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (finish) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (finish) begin
            bin_out_reg  <= rd_hit_reg ? mem_rdata : '0;
            inc_out_reg  <= inc_upd;
            omit_out_reg <= omit_upd;
            dep_out_reg  <= dep_hit_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {omit_out_reg, inc_out_reg, bin_out_reg};
    assign m_tuser  = dep_out_reg;

endmodule

`default_nettype wire
